// ===== hw/rtl/kemt_pkg.sv =====
// ----------------------------------------------------------------------------
// kemt_pkg
// shared types and constants of the keyed energy merge table
// ----------------------------------------------------------------------------
`default_nettype none

package kemt_pkg;

   // table geometry
   localparam int unsigned TableDepth  = 1024;
   localparam int unsigned SlotWidth   = 10;
   localparam int unsigned CountWidth  = 11;
   localparam int unsigned LookupWidth = 11;
   localparam int unsigned AccWidth    = 40;

   // hash multiplier, low 40 bits split in two 20-bit halves
   localparam logic [19:0] HashMulLo = 20'hA7C15;
   localparam logic [19:0] HashMulHi = 20'hB97F4;

   // request commands
   typedef enum logic [1:0] {
      CMD_MERGE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_BUCKET,
      ST_LOOK,
      ST_LWAIT,
      ST_EWAIT,
      ST_RWAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [63:0]        cell_id;
      logic signed [31:0] hit_energy;
      logic signed [31:0] hit_time;
      logic [31:0]        hit_flags;
      logic [9:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [9:0]         slot;
      logic               was_new;
      logic               table_full;
      logic [10:0]        entry_count;
      logic               index_valid;
      logic [63:0]        out_cell_id;
      logic signed [39:0] out_energy;
      logic signed [31:0] out_time;
      logic [31:0]        out_flags;
   } rsp_type;

   // one row of the entry memory
   typedef struct packed {
      logic [63:0]        cell_id;
      logic signed [39:0] energy;
      logic signed [31:0] hit_time;
      logic [31:0]        flags;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_energy_merge_table.sv =====
// merge: hash, bucket, then a lookup read per bucket probed and an entry read per occupied bucket;
// read goes through the entry memory unless out of range; clear and idle commands go straight to the response
// throughput: one request at a time, the next one taken as the response leaves (after the clearing
// pass for a clear); set by the probe loop over the lookup memory and the read-modify-write of the entry memory
// reset: a clearing pass empties all 2048 lookup buckets, with
// no request accepted; a clear request runs the same pass after its response
// ----------------------------------------------------------------------------
// keyed_energy_merge_table
// group-by-sum of calorimeter hits keyed by 64-bit cell identifier
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_energy_merge_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kemt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kemt_pkg::rsp_type      rsp_data
);

   // memories
   logic [kemt_pkg::LookupWidth-1:0] look_mem [2*kemt_pkg::TableDepth];
   kemt_pkg::entry_type              ent_mem  [kemt_pkg::TableDepth];

   kemt_pkg::state_type state_ff, state_in;
   kemt_pkg::req_type   req_ff, req_in;
   kemt_pkg::rsp_type   res_ff, res_in, rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [39:0]         p0_ff, p0_in;
   logic [19:0]         p1_ff, p1_in, p2_ff, p2_in;
   logic [kemt_pkg::LookupWidth-1:0] bucket_ff, bucket_in;
   logic [kemt_pkg::SlotWidth-1:0]   slot_ff, slot_in;
   logic [kemt_pkg::CountWidth-1:0]  used_ff, used_in;
   logic [kemt_pkg::LookupWidth-1:0] clr_ff, clr_in;

   logic                             look_we;
   logic [kemt_pkg::LookupWidth-1:0] look_addr;
   logic [kemt_pkg::LookupWidth-1:0] look_wdata;
   logic [kemt_pkg::LookupWidth-1:0] look_rd_ff;
   logic                             ent_we;
   logic [kemt_pkg::SlotWidth-1:0]   ent_waddr, ent_raddr;
   kemt_pkg::entry_type              ent_wdata, ent_rd_ff;

   logic        req_take;
   logic        out_free;
   logic [39:0] hash_x;
   logic [39:0] hash_h;
   logic [40:0] sum41;
   logic signed [39:0] sat_sum;
   kemt_pkg::entry_type new_entry;

   assign req_stall = (state_ff != kemt_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // hash datapath: low 40 bits of the product are all the bucket needs
   assign hash_x = req_ff.cell_id[39:0] ^ {7'd0, req_ff.cell_id[63:31]};
   assign hash_h = p0_ff + {(p1_ff + p2_ff), 20'd0};

   // saturating accumulate of the stored energy
   assign sum41   = {ent_rd_ff.energy[39], ent_rd_ff.energy}
                  + {{9{req_ff.hit_energy[31]}}, req_ff.hit_energy};
   assign sat_sum = (sum41[40] != sum41[39]) ?
                    (sum41[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}}) : sum41[39:0];

   assign new_entry = '{cell_id:  req_ff.cell_id,
                        energy:   {{8{req_ff.hit_energy[31]}}, req_ff.hit_energy},
                        hit_time: req_ff.hit_time,
                        flags:    req_ff.hit_flags};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kemt_pkg::ST_CLEAR: begin
            if (clr_ff == '1) state_in = kemt_pkg::ST_IDLE;
         end
         kemt_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_data.command)
                  kemt_pkg::CMD_MERGE: state_in = kemt_pkg::ST_HASH;
                  kemt_pkg::CMD_READ: begin
                     if ({1'b0, req_data.read_index} < used_ff)
                        state_in = kemt_pkg::ST_RWAIT;
                     else
                        state_in = kemt_pkg::ST_OUT;
                  end
                  default: state_in = kemt_pkg::ST_OUT;
               endcase
            end
         end
         kemt_pkg::ST_HASH:   state_in = kemt_pkg::ST_BUCKET;
         kemt_pkg::ST_BUCKET: state_in = kemt_pkg::ST_LOOK;
         kemt_pkg::ST_LOOK:   state_in = kemt_pkg::ST_LWAIT;
         kemt_pkg::ST_LWAIT: begin
            if (look_rd_ff == '0) state_in = kemt_pkg::ST_OUT;
            else                  state_in = kemt_pkg::ST_EWAIT;
         end
         kemt_pkg::ST_EWAIT: begin
            if (ent_rd_ff.cell_id == req_ff.cell_id) state_in = kemt_pkg::ST_OUT;
            else                                     state_in = kemt_pkg::ST_LOOK;
         end
         kemt_pkg::ST_RWAIT: state_in = kemt_pkg::ST_OUT;
         kemt_pkg::ST_OUT: begin
            if (out_free) begin
               if (req_ff.command == kemt_pkg::CMD_CLEAR) state_in = kemt_pkg::ST_CLEAR;
               else                                       state_in = kemt_pkg::ST_IDLE;
            end
         end
         default: state_in = kemt_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      bucket_in    = bucket_ff;
      slot_in      = slot_ff;
      used_in      = used_ff;
      clr_in       = clr_ff;
      look_we      = 1'b0;
      look_addr    = bucket_ff;
      look_wdata   = '0;
      ent_we       = 1'b0;
      ent_waddr    = slot_ff;
      ent_wdata    = new_entry;
      ent_raddr    = slot_ff;
      case (state_ff)
         // empty one bucket a cycle
         kemt_pkg::ST_CLEAR: begin
            look_we   = 1'b1;
            look_addr = clr_ff;
            clr_in    = clr_ff + 1'b1;
         end
         kemt_pkg::ST_IDLE: begin
            if (req_take) begin
               req_in    = req_data;
               res_in    = '0;
               ent_raddr = req_data.read_index;
               case (req_data.command)
                  kemt_pkg::CMD_READ: res_in.slot = req_data.read_index;
                  kemt_pkg::CMD_CLEAR: begin
                     used_in = '0;
                     clr_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         // partial products of the hash multiply
         kemt_pkg::ST_HASH: begin
            p0_in = hash_x[19:0] * kemt_pkg::HashMulLo;
            p1_in = 20'(hash_x[19:0] * kemt_pkg::HashMulHi);
            p2_in = 20'(hash_x[39:20] * kemt_pkg::HashMulLo);
         end
         kemt_pkg::ST_BUCKET: bucket_in = hash_h[10:0] ^ hash_h[39:29];
         kemt_pkg::ST_LOOK: ;
         // bucket contents: empty ends the probe with an insert or table_full, otherwise fetch the entry
         kemt_pkg::ST_LWAIT: begin
            if (look_rd_ff == '0) begin
               if (used_ff >= kemt_pkg::CountWidth'(kemt_pkg::TableDepth)) begin
                  res_in.table_full = 1'b1;
               end else begin
                  ent_we            = 1'b1;
                  ent_waddr         = used_ff[kemt_pkg::SlotWidth-1:0];
                  look_we           = 1'b1;
                  look_wdata        = used_ff + 1'b1;
                  used_in           = used_ff + 1'b1;
                  res_in.slot       = used_ff[kemt_pkg::SlotWidth-1:0];
                  res_in.was_new    = 1'b1;
                  res_in.out_cell_id = new_entry.cell_id;
                  res_in.out_energy  = new_entry.energy;
                  res_in.out_time    = new_entry.hit_time;
                  res_in.out_flags   = new_entry.flags;
               end
            end else begin
               ent_raddr = look_rd_ff[kemt_pkg::SlotWidth-1:0] - 1'b1;
               slot_in   = look_rd_ff[kemt_pkg::SlotWidth-1:0] - 1'b1;
            end
         end
         // key compare, then update in place or probe the next bucket
         kemt_pkg::ST_EWAIT: begin
            if (ent_rd_ff.cell_id == req_ff.cell_id) begin
               ent_we             = 1'b1;
               ent_wdata.energy   = sat_sum;
               res_in.slot        = slot_ff;
               res_in.out_cell_id = ent_rd_ff.cell_id;
               res_in.out_energy  = sat_sum;
               res_in.out_time    = req_ff.hit_time;
               res_in.out_flags   = req_ff.hit_flags;
            end else begin
               bucket_in = bucket_ff + 1'b1;
            end
         end
         kemt_pkg::ST_RWAIT: begin
            res_in.index_valid = 1'b1;
            res_in.out_cell_id = ent_rd_ff.cell_id;
            res_in.out_energy  = ent_rd_ff.energy;
            res_in.out_time    = ent_rd_ff.hit_time;
            res_in.out_flags   = ent_rd_ff.flags;
         end
         // hand the response to the output register
         kemt_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_in             = res_ff;
               rsp_in.entry_count = used_ff;
               rsp_valid_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kemt_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         clr_ff       <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      bucket_ff <= bucket_in;
      slot_ff   <= slot_in;
   end

   // lookup memory, one port
   always_ff @(posedge clock) begin
      if (look_we) look_mem[look_addr] <= look_wdata;
      look_rd_ff <= look_mem[look_addr];
   end

   // entry memory, one write and one read port
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      ent_rd_ff <= ent_mem[ent_raddr];
   end

endmodule

`default_nettype wire
